/* rtl/mhj_pkg.sv */
// Package for the manipulator Hessian block: column and result item layouts,
// control state type, axis tables and the saturation helper.
// No dependencies.
package mhj_pkg;

   localparam int ROWS_PER_COLUMN = 6;
   localparam int REQ_DATA_WIDTH = 96;
   localparam int RSP_DATA_WIDTH = 200;
   localparam logic [3:0] JOINT_COUNT_RESET = 4'd6;

   // Cross product component c uses axes NEXT_AXIS[c] and FAR_AXIS[c].
   localparam int NEXT_AXIS [3] = '{1, 2, 0};
   localparam int FAR_AXIS [3] = '{2, 0, 1};

   typedef logic [2:0][15:0] mhj_vec16_type;
   typedef logic [2:0][31:0] mhj_vec32_type;

   // One Jacobian column, lin_x in the lowest bits.
   typedef struct packed {
      mhj_vec16_type ang;
      mhj_vec16_type lin;
   } mhj_col_type;

   // One result item without final_item, deriv_joint in the lowest bits.
   typedef struct packed {
      logic [1:0]    pad;
      mhj_vec32_type rot;
      mhj_vec32_type trans;
      logic [2:0]    column_index;
      logic [2:0]    deriv_joint;
   } mhj_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_LOAD
   } mhj_state_type;

   function automatic logic [31:0] mhj_sat32(input logic signed [32:0] d);
      logic [31:0] r;
      if (d > 33'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (d < -33'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = d[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/mhj_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mhj_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mhj_cross.sv */
// Cross product unit: registered products of two columns, then difference and
// saturation for the translational and rotational parts (rot zero unless order_lt). Uses mhj_pkg.
module mhj_cross
   import mhj_pkg::*;
(
   input  logic          clock,
   input  logic          mul_en,
   input  logic          order_lt,
   input  mhj_col_type   col_i,
   input  mhj_col_type   col_j,
   output mhj_vec32_type trans,
   output mhj_vec32_type rot
);

   logic signed [31:0] tp_hi_ff [3];
   logic signed [31:0] tp_lo_ff [3];
   logic signed [31:0] rp_hi_ff [3];
   logic signed [31:0] rp_lo_ff [3];
   logic signed [31:0] tp_hi_in [3];
   logic signed [31:0] tp_lo_in [3];
   logic signed [31:0] rp_hi_in [3];
   logic signed [31:0] rp_lo_in [3];
   logic               lt_ff;
   mhj_vec16_type      u_vec;
   mhj_vec16_type      v_vec;

   always_comb begin
      u_vec = order_lt ? col_i.ang : col_j.ang;
      v_vec = order_lt ? col_j.lin : col_i.lin;
      for (int c = 0; c < 3; c++) begin
         tp_hi_in[c] = $signed(u_vec[NEXT_AXIS[c]]) * $signed(v_vec[FAR_AXIS[c]]);
         tp_lo_in[c] = $signed(u_vec[FAR_AXIS[c]]) * $signed(v_vec[NEXT_AXIS[c]]);
         rp_hi_in[c] = $signed(col_i.ang[NEXT_AXIS[c]]) * $signed(col_j.ang[FAR_AXIS[c]]);
         rp_lo_in[c] = $signed(col_i.ang[FAR_AXIS[c]]) * $signed(col_j.ang[NEXT_AXIS[c]]);
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         tp_hi_ff <= tp_hi_in;
         tp_lo_ff <= tp_lo_in;
         rp_hi_ff <= rp_hi_in;
         rp_lo_ff <= rp_lo_in;
         lt_ff    <= order_lt;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         trans[c] = mhj_sat32(33'(tp_hi_ff[c]) - 33'(tp_lo_ff[c]));
         rot[c]   = lt_ff ? mhj_sat32(33'(rp_hi_ff[c]) - 33'(rp_lo_ff[c])) : 32'd0;
      end
   end

endmodule

/* rtl/manipulator_hessian_from_jacobian.sv */
// Top level of the manipulator Hessian block: column store, sequencer and
// result register. Uses mhj_pkg, mhj_ram and mhj_cross.
//
//   channel  dir  payload                                       handshake
//   req_     in   one Jacobian column (lin xyz, ang xyz)        tvalid/tready
//   rsp_     out  one Hessian slice (i, j, trans, rot), tlast   tvalid/tready
//   csr_     in   joint_count                                   write enable
//
// A column is taken on each valid beat while idle. After the column that
// completes the frame, the n*n results follow, each via RAM read, multiply and
// load, while the result side is ready; no column is taken during that time.
// Reset clears the column count and sets joint_count to 6; the column store is
// not cleared. A stalled result holds the sequencer in its load step.
module manipulator_hessian_from_jacobian
   import mhj_pkg::*;
#(
   parameter int MAX_JOINTS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // deriv_joint, column_index, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, zero pad
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic [3:0]                csr_wdata
);

   localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int CW = $clog2(MAX_JOINTS + 1);

   mhj_state_type state_ff, state_in;
   logic [3:0]    joint_count_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_last_ff, rsp_last_in;
   mhj_rsp_type   rsp_data_ff, rsp_data_in;

   logic [CW-1:0] n_eff;
   logic [IW-1:0] slot;
   logic [CW-1:0] slot_next;
   logic          col_wr;
   logic          mul_en;
   logic          j_end;
   logic          i_end;
   mhj_col_type   col_i;
   mhj_col_type   col_j;
   mhj_vec32_type trans;
   mhj_vec32_type rot;
   logic [IW+2:0] i_wide;
   logic [IW+2:0] j_wide;

   mhj_ram #(
      .WIDTH (REQ_DATA_WIDTH),
      .DEPTH (MAX_JOINTS)
   ) u_ram_i (
      .clock   (clock),
      .wr_en   (col_wr),
      .wr_addr (slot),
      .wr_data (req_tdata),
      .rd_addr (i_ff),
      .rd_data (col_i)
   );

   mhj_ram #(
      .WIDTH (REQ_DATA_WIDTH),
      .DEPTH (MAX_JOINTS)
   ) u_ram_j (
      .clock   (clock),
      .wr_en   (col_wr),
      .wr_addr (slot),
      .wr_data (req_tdata),
      .rd_addr (j_ff),
      .rd_data (col_j)
   );

   mhj_cross u_cross (
      .clock    (clock),
      .mul_en   (mul_en),
      .order_lt (i_ff < j_ff),
      .col_i    (col_i),
      .col_j    (col_j),
      .trans    (trans),
      .rot      (rot)
   );

   always_comb begin
      if (joint_count_ff == 4'd0) begin
         n_eff = CW'(1);
      end else if (int'(joint_count_ff) > MAX_JOINTS) begin
         n_eff = CW'(MAX_JOINTS);
      end else begin
         n_eff = CW'(joint_count_ff);
      end
      if (int'(count_ff) >= MAX_JOINTS) begin
         slot = IW'(MAX_JOINTS - 1);
      end else begin
         slot = IW'(count_ff);
      end
      slot_next = CW'(slot) + CW'(1);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign col_wr     = req_tvalid && req_tready;
   assign j_end      = (CW'(j_ff) == n_ff - CW'(1));
   assign i_end      = (CW'(i_ff) == n_ff - CW'(1));
   assign i_wide     = {3'b000, i_ff};
   assign j_wide     = {3'b000, j_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      mul_en       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (col_wr) begin
               if (slot_next >= n_eff) begin
                  count_in = '0;
                  n_in     = n_eff;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_READ;
               end else begin
                  count_in = slot_next;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            mul_en   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in              = 1'b1;
               rsp_last_in               = i_end && j_end;
               rsp_data_in.pad           = 2'b00;
               rsp_data_in.deriv_joint   = i_wide[2:0];
               rsp_data_in.column_index  = j_wide[2:0];
               rsp_data_in.trans         = trans;
               rsp_data_in.rot           = rot;
               if (j_end) begin
                  j_in = '0;
                  i_in = i_ff + IW'(1);
               end else begin
                  j_in = j_ff + IW'(1);
               end
               state_in = (i_end && j_end) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         joint_count_ff <= JOINT_COUNT_RESET;
         count_ff       <= '0;
         n_ff           <= CW'(1);
         i_ff           <= '0;
         j_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         if (csr_we) begin
            joint_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
